@@ src/idpa_pkg.sv @@
// ----------------------------------------------------------------------------
// idpa_pkg
// Shared types and codes for the identifier pool allocator: command and
// status codes, beat payload structs and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package idpa_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int ID_W         = 7;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  free_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]     given_id;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_ALLOC_RD = 5'b00010,
        ST_SEARCH  = 5'b00100,
        ST_SWAP_RD = 5'b01000,
        ST_SWAP_WR = 5'b10000
    } state_t;

endpackage

`default_nettype wire

@@ src/idpa_table.sv @@
// ----------------------------------------------------------------------------
// idpa_table
// Identifier table: single write port, single read port and registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module idpa_table #(
    parameter int DEPTH = idpa_pkg::CAPACITY_DEF,
    parameter int WIDTH = idpa_pkg::ID_W
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/id_pool_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// id_pool_allocator_unit
// Identifier pool allocator. Issues fresh identifiers, reuses freed ones and
// takes identifiers back by searching the in-use part of a table held in a
// synchronous memory.
//
//   channel   signals                 beat taken when
//   command   start, busy, req        start high and busy low
//   result    done, rsp               done high (one cycle, no back-pressure)
//
// Clear, a full allocate and a fresh allocate finish from idle; a reuse
// allocate makes one table read. A free scans the in-use part one entry per
// cycle through the table read port; on a hit, ST_SWAP_RD writes the last
// live entry into the hit slot and ST_SWAP_WR writes the freed identifier
// into the last slot. busy holds off commands while a table access is in
// flight. Reset clears the counts; the table needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module id_pool_allocator_unit #(
    parameter int CAPACITY = idpa_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire idpa_pkg::req_t req,
    output logic               busy,
    output logic               done,
    output idpa_pkg::rsp_t     rsp
);

    import idpa_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (AW > ID_W) ? AW : ID_W;

    state_t          state_reg, state_next;
    logic [CW-1:0]   live_reg, live_next;
    logic [CW-1:0]   issued_reg, issued_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0] want_reg, want_next;
    rsp_t            rsp_reg, rsp_next;
    logic            done_reg, done_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [EW-1:0]   mem_rdata;
    logic [AW-1:0]   last_idx;

    idpa_table #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign last_idx = AW'(live_reg - 1'b1);

    always_comb
    begin
        state_next  = state_reg;
        live_next   = live_reg;
        issued_next = issued_reg;
        idx_next    = idx_reg;
        want_next   = want_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.cmd)
                        CMD_ALLOC:
                        begin
                            if (live_reg >= CW'(CAPACITY))
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{given_id: '0, status: STATUS_FULL};
                            end
                            else if (live_reg == issued_reg)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = issued_reg[AW-1:0];
                                mem_wdata   = EW'(issued_reg[AW-1:0]);
                                live_next   = live_reg + 1'b1;
                                issued_next = issued_reg + 1'b1;
                                done_next   = 1'b1;
                                rsp_next    = '{given_id: ID_W'(issued_reg[AW-1:0]),
                                                status: STATUS_OK};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = live_reg[AW-1:0];
                                state_next = ST_ALLOC_RD;
                            end
                        end
                        CMD_FREE:
                        begin
                            want_next = req.free_id;
                            if (live_reg == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{given_id: '0, status: STATUS_NOT_FOUND};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            live_next   = '0;
                            issued_next = '0;
                            done_next   = 1'b1;
                            rsp_next    = '{given_id: '0, status: STATUS_OK};
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{given_id: '0, status: STATUS_OK};
                        end
                    endcase
                end
            end
            ST_ALLOC_RD:
            begin
                live_next  = live_reg + 1'b1;
                done_next  = 1'b1;
                rsp_next   = '{given_id: ID_W'(mem_rdata), status: STATUS_OK};
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (mem_rdata == EW'(want_reg))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = last_idx;
                    state_next = ST_SWAP_RD;
                end
                else if (idx_reg == last_idx)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{given_id: '0, status: STATUS_NOT_FOUND};
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_reg + 1'b1);
                    idx_next  = AW'(idx_reg + 1'b1);
                end
            end
            ST_SWAP_RD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = mem_rdata;
                state_next = ST_SWAP_WR;
            end
            ST_SWAP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = last_idx;
                mem_wdata  = EW'(want_reg);
                live_next  = live_reg - 1'b1;
                done_next  = 1'b1;
                rsp_next   = '{given_id: '0, status: STATUS_OK};
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            live_reg   <= '0;
            issued_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            live_reg   <= live_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        want_reg <= want_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_live_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= issued_reg)
        else $error("live count above issued mark");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg <= CW'(CAPACITY))
        else $error("issued mark above capacity");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted beat neither finished nor in progress");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE))
        else $error("result beat while a command is still in progress");

    a_miss_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STATUS_NOT_FOUND) |-> (live_reg == $past(live_reg)))
        else $error("failed free changed the live count");

endmodule

`default_nettype wire

@@ sim/id_pool_allocator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_pool_allocator_checker
// Watches the command and result channels of the identifier pool allocator.
// It keeps its own copy of the identifier table and both counts and works
// out the result of every accepted command. Each result beat is checked
// field by field against the oldest pending result. The number of pending
// results and the failure count go back to the test top.
// ----------------------------------------------------------------------------
module id_pool_allocator_checker #(
    parameter int CAPACITY = idpa_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  idpa_pkg::req_t req,
    input  logic           done,
    input  idpa_pkg::rsp_t rsp,
    output int             pending,
    output int             fail_count
);
    import idpa_pkg::*;

    logic [ID_W-1:0] pool_ids [CAPACITY];
    int              live_count;
    int              issued_mark;
    rsp_t            pending_rsp_q [$];

    initial fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic rsp_t apply_pool_command(input req_t beat);
        rsp_t outcome;
        int   hit;
        outcome = '{given_id: '0, status: STATUS_OK};
        case (beat.cmd)
            CMD_ALLOC:
            begin
                if (live_count >= CAPACITY) begin
                    outcome.status = STATUS_FULL;
                end
                else begin
                    if (live_count == issued_mark) begin
                        pool_ids[issued_mark] = issued_mark[ID_W-1:0];
                        issued_mark++;
                    end
                    outcome.given_id = pool_ids[live_count];
                    live_count++;
                end
            end
            CMD_FREE:
            begin
                hit = live_count;
                for (int k = 0; k < live_count; k++) begin
                    if (pool_ids[k] == beat.free_id) begin
                        hit = k;
                        break;
                    end
                end
                if (hit < live_count) begin
                    pool_ids[hit] = pool_ids[live_count-1];
                    pool_ids[live_count-1] = beat.free_id;
                    live_count--;
                end
                else begin
                    outcome.status = STATUS_NOT_FOUND;
                end
            end
            CMD_CLEAR:
            begin
                live_count = 0;
                issued_mark = 0;
            end
            default:
            begin
            end
        endcase
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            live_count = 0;
            issued_mark = 0;
            pending_rsp_q.delete();
            pending <= 0;
        end
        else begin
            if (start && !busy) begin
                pending_rsp_q.push_back(apply_pool_command(req));
            end
            if (done) begin
                if (pending_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat: id %0d status %0d",
                                              rsp.given_id, rsp.status));
                end
                else begin
                    want = pending_rsp_q.pop_front();
                    if (rsp.given_id !== want.given_id) begin
                        report_mismatch($sformatf("given_id %0d, predicted %0d",
                                                  rsp.given_id, want.given_id));
                    end
                    if (rsp.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  rsp.status, want.status));
                    end
                end
            end
            pending <= pending_rsp_q.size();
        end
    end

endmodule

@@ sim/id_pool_allocator_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_pool_allocator_unit_test
// Test top for the identifier pool allocator. Runs a directed sequence over
// empty pool, reuse, swap on free, misses, clear and the unused command,
// then runs of random commands that grow, shrink and fill the pool, with
// random gaps between command beats. The checker beside the block predicts
// and compares; this top drives commands and gives the verdict.
// ----------------------------------------------------------------------------
module id_pool_allocator_unit_test;
    import idpa_pkg::*;

    localparam int              CAPACITY     = CAPACITY_DEF;
    localparam int              RANDOM_ITEMS = 750;
    localparam int              IDLE_LIMIT   = 20 * (CAPACITY + 16);
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    typedef enum int {
        MODE_GROW,
        MODE_MIXED,
        MODE_SHRINK,
        MODE_FILL
    } pool_mode_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    req_t       req;
    rsp_t       rsp;
    int         pending;
    int         fail_count;
    int         gap_max;
    int         allocs_since_clear;
    int         idle_cycles = 0;

    id_pool_allocator_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .busy (busy),
        .done (done),
        .rsp  (rsp)
    );

    id_pool_allocator_checker #(
        .CAPACITY(CAPACITY)
    ) checker_inst (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .pending   (pending),
        .fail_count(fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{cmd: op, free_id: id};
        do @(posedge clk); while (busy);
        if (op == CMD_ALLOC && allocs_since_clear < CAPACITY) begin
            allocs_since_clear++;
        end
        else if (op == CMD_CLEAR) begin
            allocs_since_clear = 0;
        end
    endtask

    task automatic send_random(input pool_mode_t mode);
        int              roll;
        int              alloc_pct;
        logic [ID_W-1:0] id;
        case (mode)
            MODE_GROW:   alloc_pct = 75;
            MODE_SHRINK: alloc_pct = 25;
            MODE_FILL:   alloc_pct = 100;
            default:     alloc_pct = 50;
        endcase
        roll = $urandom_range(0, 99);
        if (allocs_since_clear == 0 || $urandom_range(0, 3) == 0) begin
            id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
        end
        else begin
            id = ID_W'($urandom_range(0, allocs_since_clear - 1));
        end
        if (roll < alloc_pct) begin
            send_command(CMD_ALLOC, id);
        end
        else if (roll < 98) begin
            send_command(CMD_FREE, id);
        end
        else if (roll < 99) begin
            send_command(CMD_CLEAR, id);
        end
        else begin
            send_command(CMD_UNUSED, id);
        end
    endtask

    initial begin
        int         sent;
        int         run_len;
        bit         fill_done;
        bit         paused;
        pool_mode_t mode;

        rst_n = 1'b0;
        start <= 1'b0;
        req   <= '0;
        gap_max = 14;
        allocs_since_clear = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_command(CMD_FREE, 7'd0);
        send_command(CMD_FREE, 7'd127);
        send_command(CMD_ALLOC, 7'd127);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_FREE, 7'd127);
        send_command(CMD_FREE, 7'd2);
        send_command(CMD_FREE, 7'd0);
        send_command(CMD_FREE, 7'd3);
        send_command(CMD_FREE, 7'd3);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_UNUSED, 7'd0);
        send_command(CMD_UNUSED, 7'd127);
        send_command(CMD_CLEAR, 7'd0);
        send_command(CMD_FREE, 7'd1);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_ALLOC, 7'd0);
        send_command(CMD_FREE, 7'd1);
        send_command(CMD_CLEAR, 7'd127);

        sent = 0;
        fill_done = 1'b0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            run_len = $urandom_range(30, 60);
            mode = pool_mode_t'($urandom_range(0, 2));
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            if (!fill_done && sent >= 150) begin
                mode = MODE_FILL;
                run_len = CAPACITY + 12;
                fill_done = 1'b1;
            end
            repeat (run_len) begin
                send_random(mode);
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                paused = 1'b1;
                do @(posedge clk); while (pending != 0);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (CAPACITY + 10) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/idpa_pkg.sv
src/idpa_table.sv
src/id_pool_allocator_unit.sv
sim/id_pool_allocator_checker.sv
sim/id_pool_allocator_unit_test.sv
